// ===== rtl/sts_pkg.sv =====
package sts_pkg;

	localparam int KindW = 6;
	localparam int FieldW = 20;

	localparam logic [0:0] OP_BYTE = 1'b0;
	localparam logic [0:0] OP_END  = 1'b1;

	localparam logic [KindW-1:0] K_EOF     = 6'd0;
	localparam logic [KindW-1:0] K_INVALID = 6'd1;
	localparam logic [KindW-1:0] K_NUMBER  = 6'd2;
	localparam logic [KindW-1:0] K_IDENT   = 6'd3;
	localparam logic [KindW-1:0] K_STRING  = 6'd4;
	localparam logic [KindW-1:0] K_KW_BASE = 6'd5;
	localparam logic [KindW-1:0] K_PLUS_EQ = 6'd25;
	localparam logic [KindW-1:0] K_PLUS2   = 6'd26;
	localparam logic [KindW-1:0] K_PLUS    = 6'd27;
	localparam logic [KindW-1:0] K_MINUS_EQ = 6'd28;
	localparam logic [KindW-1:0] K_MINUS2  = 6'd29;
	localparam logic [KindW-1:0] K_MINUS   = 6'd30;
	localparam logic [KindW-1:0] K_STAR_EQ = 6'd31;
	localparam logic [KindW-1:0] K_STAR    = 6'd32;
	localparam logic [KindW-1:0] K_SLASH_EQ = 6'd33;
	localparam logic [KindW-1:0] K_SLASH   = 6'd34;
	localparam logic [KindW-1:0] K_CARET_EQ = 6'd35;
	localparam logic [KindW-1:0] K_CARET   = 6'd36;
	localparam logic [KindW-1:0] K_COMMA   = 6'd37;
	localparam logic [KindW-1:0] K_SEMI    = 6'd38;
	localparam logic [KindW-1:0] K_LPAREN  = 6'd39;
	localparam logic [KindW-1:0] K_RPAREN  = 6'd40;
	localparam logic [KindW-1:0] K_LBRACK  = 6'd41;
	localparam logic [KindW-1:0] K_RBRACK  = 6'd42;
	localparam logic [KindW-1:0] K_LBRACE  = 6'd43;
	localparam logic [KindW-1:0] K_RBRACE  = 6'd44;
	localparam logic [KindW-1:0] K_EQ2     = 6'd45;
	localparam logic [KindW-1:0] K_ASSIGN  = 6'd46;
	localparam logic [KindW-1:0] K_LE      = 6'd47;
	localparam logic [KindW-1:0] K_LT      = 6'd48;
	localparam logic [KindW-1:0] K_GE      = 6'd49;
	localparam logic [KindW-1:0] K_GT      = 6'd50;
	localparam logic [KindW-1:0] K_NE      = 6'd51;
	localparam logic [KindW-1:0] K_DOT     = 6'd52;

	localparam int KwCount = 20;
	localparam int KwChars = 8;

	typedef enum logic [2:0] {
		M_IDLE    = 3'd0,
		M_COMMENT = 3'd1,
		M_NUMBER  = 3'd2,
		M_WORD    = 3'd3,
		M_STRING  = 3'd4,
		M_OPER    = 3'd5
	} scan_mode_t;

	typedef struct packed {
		logic [0:0] operation;
		logic [7:0] source_byte;
	} in_item_t;

	typedef struct packed {
		logic [KindW-1:0]  token_kind;
		logic [FieldW-1:0] token_start;
		logic [FieldW-1:0] token_length;
		logic [FieldW-1:0] token_line;
		logic              last_of_run;
	} out_item_t;

	// Keyword text, first char in the low byte, zero padded.
	function automatic logic [8*KwChars-1:0] kw_text(input logic [4:0] k);
		logic [8*KwChars-1:0] t;
		case (k)
			5'd0:  t = 64'h0000_0000_0064_6e61; // and
			5'd1:  t = 64'h0000_0000_0000_7361; // as
			5'd2:  t = 64'h0000_0073_7361_6c63; // class
			5'd3:  t = 64'h0000_0074_736e_6f63; // const
			5'd4:  t = 64'h0000_0000_6669_6c65; // elif
			5'd5:  t = 64'h0000_0000_6573_6c65; // else
			5'd6:  t = 64'h0000_0000_0072_6f66; // for
			5'd7:  t = 64'h6e6f_6974_636e_7566; // function
			5'd8:  t = 64'h0000_0000_0000_6669; // if
			5'd9:  t = 64'h0000_0000_6461_6f6c; // load
			5'd10: t = 64'h0000_656c_7564_6f6d; // module
			5'd11: t = 64'h0000_0000_656e_6f6e; // none
			5'd12: t = 64'h0000_0000_0074_6f6e; // not
			5'd13: t = 64'h0000_0000_0000_726f; // or
			5'd14: t = 64'h0000_0074_6e69_7270; // print
			5'd15: t = 64'h0000_6e72_7574_6572; // return
			5'd16: t = 64'h0000_6369_7461_7473; // static
			5'd17: t = 64'h0000_0000_0065_7375; // use
			5'd18: t = 64'h0000_0000_0072_6176; // var
			5'd19: t = 64'h0000_0065_6c69_6877; // while
			default: t = '0;
		endcase
		return t;
	endfunction

	function automatic logic [3:0] kw_len(input logic [4:0] k);
		logic [3:0] n;
		case (k)
			5'd1, 5'd8, 5'd13: n = 4'd2;
			5'd0, 5'd6, 5'd12, 5'd17, 5'd18: n = 4'd3;
			5'd4, 5'd5, 5'd9, 5'd11: n = 4'd4;
			5'd2, 5'd3, 5'd14, 5'd19: n = 4'd5;
			5'd10, 5'd15, 5'd16: n = 4'd6;
			5'd7: n = 4'd8;
			default: n = 4'd0;
		endcase
		return n;
	endfunction

	function automatic logic is_digit(input logic [7:0] c);
		return (c >= 8'h30) && (c <= 8'h39);
	endfunction

	function automatic logic is_alpha(input logic [7:0] c);
		return ((c >= 8'h61) && (c <= 8'h7a)) || ((c >= 8'h41) && (c <= 8'h5a));
	endfunction

	function automatic logic is_ident(input logic [7:0] c);
		return is_alpha(c) || is_digit(c) || (c == 8'h5f);
	endfunction

endpackage

// ===== rtl/sts_queue.sv =====
module sts_queue
	import sts_pkg::*;
#(
	parameter int Depth = 2
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      wr_valid,
	output logic      wr_stall,
	input  in_item_t  wr_data,
	output logic      rd_valid,
	input  logic      rd_stall,
	output in_item_t  rd_data
);
	localparam int AW = (Depth > 1) ? $clog2(Depth) : 1;

	in_item_t        slot_q [Depth];
	logic [AW-1:0]   wptr_q, rptr_q;
	logic [AW:0]     cnt_q;
	logic            do_wr, do_rd;

	assign wr_stall = (cnt_q == (AW+1)'(Depth));
	assign rd_valid = (cnt_q != '0);
	assign rd_data  = slot_q[rptr_q];
	assign do_wr    = wr_valid && !wr_stall;
	assign do_rd    = rd_valid && !rd_stall;

	always_ff @(posedge clk) begin
		if (do_wr) begin
			slot_q[wptr_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= '0;
			rptr_q <= '0;
			cnt_q  <= '0;
		end else begin
			if (do_wr) begin
				wptr_q <= (wptr_q == AW'(Depth - 1)) ? '0 : wptr_q + 1'b1;
			end
			if (do_rd) begin
				rptr_q <= (rptr_q == AW'(Depth - 1)) ? '0 : rptr_q + 1'b1;
			end
			case ({do_wr, do_rd})
				2'b10:   cnt_q <= cnt_q + 1'b1;
				2'b01:   cnt_q <= cnt_q - 1'b1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end
endmodule

// ===== rtl/sts_back.sv =====
module sts_back
	import sts_pkg::*;
#(
	parameter int OffsetBits = 20
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      item_valid,
	output logic      item_stall,
	input  in_item_t  item,
	output logic      tok_valid,
	input  logic      tok_stall,
	output out_item_t tok
);
	localparam logic [OffsetBits-1:0] OffMax = '1;

	scan_mode_t               mode_q;
	logic [7:0]               pend_q;
	logic [OffsetBits-1:0]    off_q, line_q, beg_q, begl_q;
	logic                     point_q;
	logic [8*KwChars-1:0]     word_q;

	// output buffer: up to two tokens per transaction
	out_item_t                buf_q [2];
	logic [1:0]               cnt_q;
	logic                     rd_q;

	// step outputs
	scan_mode_t               mode_d;
	logic [7:0]               pend_d;
	logic [OffsetBits-1:0]    off_d, line_d, beg_d, begl_d;
	logic                     point_d;
	logic [8*KwChars-1:0]     word_d;
	out_item_t                e0, e1;
	logic [1:0]               ne;
	logic                     take;

	function automatic logic [FieldW-1:0] fw(input logic [OffsetBits-1:0] v);
		logic [FieldW-1:0] r;
		r = '0;
		for (int i = 0; i < FieldW && i < OffsetBits; i++) r[i] = v[i];
		return r;
	endfunction

	function automatic logic [OffsetBits-1:0] sinc(input logic [OffsetBits-1:0] v);
		return (v == OffMax) ? v : v + 1'b1;
	endfunction

	// a new byte may enter while the last buffered token leaves
	assign item_stall = (cnt_q > 2'd1) || (cnt_q == 2'd1 && tok_stall);
	assign take = item_valid && !item_stall;
	assign tok_valid = (cnt_q != 2'd0);
	assign tok = buf_q[rd_q];

	always_comb begin
		logic [7:0]            c;
		logic [OffsetBits-1:0] sp;
		logic [KindW-1:0]      wk, ok;
		logic                  two, restart, is_end;
		out_item_t             t;

		mode_d = mode_q; pend_d = pend_q; off_d = off_q; line_d = line_q;
		beg_d = beg_q; begl_d = begl_q; point_d = point_q; word_d = word_q;
		e0 = '0; e1 = '0; ne = 2'd0;
		c = item.source_byte;
		is_end = (item.operation == OP_END);
		sp = (off_q >= beg_q) ? off_q - beg_q : '0;
		restart = 1'b0;

		wk = K_IDENT;
		if (sp >= OffsetBits'(1) && sp <= OffsetBits'(KwChars)) begin
			for (int k = KwCount - 1; k >= 0; k--) begin
				if (OffsetBits'(kw_len(5'(k))) == sp && kw_text(5'(k)) == word_q)
					wk = K_KW_BASE + KindW'(k);
			end
		end

		two = 1'b0;
		ok  = K_INVALID;
		case (pend_q)
			8'h2b: begin
				if (!is_end && c == 8'h3d) begin two = 1'b1; ok = K_PLUS_EQ; end
				else if (!is_end && c == 8'h2b) begin two = 1'b1; ok = K_PLUS2; end
				else ok = K_PLUS;
			end
			8'h2d: begin
				if (!is_end && c == 8'h3d) begin two = 1'b1; ok = K_MINUS_EQ; end
				else if (!is_end && c == 8'h2d) begin two = 1'b1; ok = K_MINUS2; end
				else ok = K_MINUS;
			end
			8'h2a: begin two = !is_end && c == 8'h3d; ok = two ? K_STAR_EQ : K_STAR; end
			8'h2f: begin two = !is_end && c == 8'h3d; ok = two ? K_SLASH_EQ : K_SLASH; end
			8'h5e: begin two = !is_end && c == 8'h3d; ok = two ? K_CARET_EQ : K_CARET; end
			8'h3d: begin two = !is_end && c == 8'h3d; ok = two ? K_EQ2 : K_ASSIGN; end
			8'h3c: begin two = !is_end && c == 8'h3d; ok = two ? K_LE : K_LT; end
			8'h3e: begin two = !is_end && c == 8'h3d; ok = two ? K_GE : K_GT; end
			8'h21: begin two = !is_end && c == 8'h3d; ok = two ? K_NE : K_INVALID; end
			8'h2e: ok = K_DOT;
			default: ok = K_INVALID;
		endcase

		t = '0;
		if (is_end) begin
			case (mode_q)
				M_NUMBER: begin t.token_kind = K_NUMBER; t.token_length = fw(sp); end
				M_WORD:   begin t.token_kind = wk; t.token_length = fw(sp); end
				M_STRING: begin t.token_kind = K_INVALID; t.token_length = FieldW'(1); end
				M_OPER:   begin t.token_kind = ok; t.token_length = FieldW'(1); end
				default:  t.token_kind = K_EOF;
			endcase
			t.token_start = fw(beg_q);
			t.token_line  = fw(begl_q);
			e1.token_kind   = K_EOF;
			e1.token_start  = fw(off_q);
			e1.token_length = FieldW'(1);
			e1.token_line   = fw(line_q);
			e1.last_of_run  = 1'b1;
			if (mode_q == M_NUMBER || mode_q == M_WORD || mode_q == M_STRING
			    || mode_q == M_OPER) begin
				e0 = t; ne = 2'd2;
			end else begin
				e0 = e1; ne = 2'd1;
			end
			mode_d = M_IDLE; pend_d = '0; off_d = '0; line_d = OffsetBits'(1);
			beg_d = '0; begl_d = OffsetBits'(1); point_d = 1'b0; word_d = '0;
		end else begin
			case (mode_q)
				M_COMMENT: if (c == 8'h0a) begin
					line_d = sinc(line_q); mode_d = M_IDLE;
				end
				M_STRING: begin
					if (c == 8'h22) begin
						t.token_kind = K_STRING; t.token_start = fw(beg_q);
						t.token_length = fw(sp); t.token_line = fw(begl_q);
						e0 = t; ne = 2'd1; mode_d = M_IDLE;
					end else if (c == 8'h0a) begin
						line_d = sinc(line_q);
					end
				end
				M_NUMBER: begin
					if (is_digit(c)) begin
					end else if (c == 8'h2e && !point_q) begin
						point_d = 1'b1;
					end else begin
						t.token_kind = K_NUMBER; t.token_start = fw(beg_q);
						t.token_length = fw(sp); t.token_line = fw(begl_q);
						e0 = t; ne = 2'd1; restart = 1'b1;
					end
				end
				M_WORD: begin
					if (is_ident(c)) begin
						for (int i = 0; i < KwChars; i++)
							if (sp == OffsetBits'(i)) word_d[8*i +: 8] = c;
					end else begin
						t.token_kind = wk; t.token_start = fw(beg_q);
						t.token_length = fw(sp); t.token_line = fw(begl_q);
						e0 = t; ne = 2'd1; restart = 1'b1;
					end
				end
				M_OPER: begin
					if (pend_q == 8'h2e && is_digit(c)) begin
						mode_d = M_NUMBER; point_d = 1'b1;
					end else begin
						t.token_kind = ok; t.token_start = fw(beg_q);
						t.token_length = two ? FieldW'(2) : FieldW'(1);
						t.token_line = fw(begl_q);
						e0 = t; ne = 2'd1;
						if (two) mode_d = M_IDLE;
						else restart = 1'b1;
					end
				end
				default: restart = 1'b1;
			endcase

			if (restart) begin
				mode_d = M_IDLE;
				t = '0;
				t.token_start = fw(off_q);
				t.token_length = FieldW'(1);
				t.token_line = fw(line_d);
				case (c)
					8'h23: mode_d = M_COMMENT;
					8'h0a: line_d = sinc(line_d);
					8'h20: ;
					8'h22: begin
						mode_d = M_STRING; beg_d = sinc(off_q); begl_d = line_d;
					end
					8'h2c: t.token_kind = K_COMMA;
					8'h3b: t.token_kind = K_SEMI;
					8'h28: t.token_kind = K_LPAREN;
					8'h29: t.token_kind = K_RPAREN;
					8'h5b: t.token_kind = K_LBRACK;
					8'h5d: t.token_kind = K_RBRACK;
					8'h7b: t.token_kind = K_LBRACE;
					8'h7d: t.token_kind = K_RBRACE;
					8'h2b, 8'h2d, 8'h2a, 8'h2f, 8'h5e, 8'h3d, 8'h3c, 8'h3e, 8'h21, 8'h2e: begin
						mode_d = M_OPER; beg_d = off_q; begl_d = line_d; pend_d = c;
					end
					default: begin
						if (is_digit(c)) begin
							mode_d = M_NUMBER; beg_d = off_q; begl_d = line_d; point_d = 1'b0;
						end else if (is_alpha(c) || c == 8'h5f) begin
							mode_d = M_WORD; beg_d = off_q; begl_d = line_d;
							word_d = {56'd0, c};
						end else begin
							t.token_kind = K_INVALID;
						end
					end
				endcase
				if (c == 8'h2c || c == 8'h3b || c == 8'h28 || c == 8'h29 || c == 8'h5b
				    || c == 8'h5d || c == 8'h7b || c == 8'h7d
				    || (mode_d == M_IDLE && c != 8'h23 && c != 8'h0a && c != 8'h20
				        && !is_digit(c) && !is_alpha(c) && c != 8'h5f && c != 8'h22
				        && c != 8'h2b && c != 8'h2d && c != 8'h2a && c != 8'h2f
				        && c != 8'h5e && c != 8'h3d && c != 8'h3c && c != 8'h3e
				        && c != 8'h21 && c != 8'h2e)) begin
					if (ne == 2'd0) begin e0 = t; ne = 2'd1; end
					else begin e1 = t; ne = 2'd2; end
				end
			end
			off_d = sinc(off_q);
			if (ne == 2'd1) e0.last_of_run = 1'b1;
			if (ne == 2'd2) e1.last_of_run = 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			buf_q[0] <= e0;
			buf_q[1] <= e1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= M_IDLE; pend_q <= '0; off_q <= '0; line_q <= OffsetBits'(1);
			beg_q <= '0; begl_q <= OffsetBits'(1); point_q <= 1'b0; word_q <= '0;
			cnt_q <= 2'd0; rd_q <= 1'b0;
		end else if (take) begin
			mode_q <= mode_d; pend_q <= pend_d; off_q <= off_d; line_q <= line_d;
			beg_q <= beg_d; begl_q <= begl_d; point_q <= point_d; word_q <= word_d;
			cnt_q <= ne; rd_q <= 1'b0;
		end else if (tok_valid && !tok_stall) begin
			cnt_q <= cnt_q - 1'b1;
			rd_q  <= 1'b1;
		end
	end
endmodule

// ===== rtl/script_token_scanner.sv =====
// channel | dir | payload    | handshake
// in      | in  | in_item_t  | in_valid / in_stall
// out     | out | out_item_t | out_valid / out_stall
// One byte per cycle when each byte makes at most one token and the output
// is not stalled; a byte that makes two tokens holds the scanner while the
// second drains. A two-entry queue sits between the input and the scanner
// so each side stalls on its own. Bytes are registered in the queue, tokens
// in the output buffer. Reset is asynchronous, active low; it clears the
// queue, the scan state and the output buffer.
module script_token_scanner
	import sts_pkg::*;
#(
	parameter int OFFSET_BITS = 20
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_stall,
	input  in_item_t  in_data,
	output logic      out_valid,
	input  logic      out_stall,
	output out_item_t out_data
);
	logic     q_valid, q_stall;
	in_item_t q_data;

	// front: buffer and hand raw transactions onward
	sts_queue #(.Depth(2)) u_queue (
		.clk, .arst_n,
		.wr_valid(in_valid), .wr_stall(in_stall), .wr_data(in_data),
		.rd_valid(q_valid), .rd_stall(q_stall), .rd_data(q_data)
	);

	// back: classify byte, update scan state, emit tokens
	sts_back #(.OffsetBits(OFFSET_BITS)) u_back (
		.clk, .arst_n,
		.item_valid(q_valid), .item_stall(q_stall), .item(q_data),
		.tok_valid(out_valid), .tok_stall(out_stall), .tok(out_data)
	);
endmodule

// ===== rtl/sts_checker.sv =====
module sts_checker
	import sts_pkg::*;
(
	input logic      clk,
	input logic      arst_n,
	input logic      in_valid,
	input logic      in_stall,
	input in_item_t  in_data,
	input logic      out_valid,
	input logic      out_stall,
	input out_item_t out_data
);
	a_in_hold: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_stall |=> in_valid && $stable(in_data))
		else $error("stalled input transaction changed");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(out_data))
		else $error("stalled token changed");

	a_kind_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> out_data.token_kind <= K_DOT)
		else $error("token kind out of range");

	a_eof_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.token_kind == K_EOF |-> out_data.last_of_run)
		else $error("EOF not last");

	a_line_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> out_data.token_line != '0)
		else $error("line zero");
endmodule

bind script_token_scanner sts_checker u_sts_checker (
	.clk, .arst_n, .in_valid, .in_stall, .in_data, .out_valid, .out_stall, .out_data
);

// ===== sim/tb_script_token_scanner.sv =====
module tb_script_token_scanner;
	import sts_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int OffBits = 20;
	localparam logic [FieldW-1:0] OffMax = FieldW'((1 << OffBits) - 1);
	localparam int CycleLimit = 400000;

	logic      clk;
	logic      arst_n;
	logic      in_valid;
	logic      in_stall;
	in_item_t  in_data;
	logic      out_valid;
	logic      out_stall;
	out_item_t out_data;

	script_token_scanner #(.OFFSET_BITS(OffBits)) DUT (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
		.out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
	);

	// Scanner shadow state
	scan_mode_t        sh_mode;
	logic [7:0]        sh_pend;
	logic [FieldW-1:0] sh_off, sh_line, sh_beg, sh_beg_line;
	logic              sh_point;
	logic [63:0]       sh_prefix;

	in_item_t  src_q[$];      // transactions waiting for the driver
	out_item_t token_q[$];    // expected tokens, oldest first
	out_item_t step_toks[$];  // tokens of the byte being scanned
	int        errors;
	int        send_idle_pct, recv_idle_pct;
	bit        stim_done;
	longint    cycles;

	function automatic logic [FieldW-1:0] sat_inc(logic [FieldW-1:0] v);
		return (v < OffMax) ? v + 1'b1 : v;
	endfunction

	function automatic logic dig(logic [7:0] c);
		return c >= "0" && c <= "9";
	endfunction

	function automatic logic alpha(logic [7:0] c);
		return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
	endfunction

	function automatic logic [FieldW-1:0] span_len();
		return (sh_off >= sh_beg) ? sh_off - sh_beg : '0;
	endfunction

	function automatic void push_tok(logic [KindW-1:0] k, logic [FieldW-1:0] s,
			logic [FieldW-1:0] l, logic [FieldW-1:0] ln);
		out_item_t t;
		t.token_kind = k;
		t.token_start = s;
		t.token_length = l;
		t.token_line = ln;
		t.last_of_run = 1'b0;
		if (step_toks.size() < 2)
			step_toks.push_back(t);
	endfunction

	function automatic void sh_clear();
		sh_mode = M_IDLE;
		sh_pend = '0;
		sh_off = '0;
		sh_line = 1;
		sh_beg = '0;
		sh_beg_line = 1;
		sh_point = 1'b0;
		sh_prefix = '0;
	endfunction

	// Keyword lookup by string compare on the gathered prefix
	function automatic void word_done();
		string words[20] = '{"and", "as", "class", "const", "elif", "else", "for",
			"function", "if", "load", "module", "none", "not", "or", "print",
			"return", "static", "use", "var", "while"};
		logic [FieldW-1:0] len;
		logic [KindW-1:0]  k;
		string             w;
		len = span_len();
		k = K_IDENT;
		if (len >= 1 && len <= 8) begin
			w = "";
			for (int i = 0; i < len; i++)
				w = {w, string'(sh_prefix[8*i +: 8])};
			for (int j = 0; j < 20; j++)
				if (k == K_IDENT && w == words[j])
					k = K_KW_BASE + KindW'(j);
		end
		push_tok(k, sh_beg, len, sh_beg_line);
	endfunction

	// Operator kind; two set when the follower byte is consumed too
	function automatic logic [KindW-1:0] op_kind(logic [7:0] p, logic [7:0] c, output logic two);
		two = 1'b0;
		case (p)
			"+": if (c == "=") begin two = 1; return K_PLUS_EQ; end
				else if (c == "+") begin two = 1; return K_PLUS2; end else return K_PLUS;
			"-": if (c == "=") begin two = 1; return K_MINUS_EQ; end
				else if (c == "-") begin two = 1; return K_MINUS2; end else return K_MINUS;
			"*": if (c == "=") begin two = 1; return K_STAR_EQ; end else return K_STAR;
			"/": if (c == "=") begin two = 1; return K_SLASH_EQ; end else return K_SLASH;
			"^": if (c == "=") begin two = 1; return K_CARET_EQ; end else return K_CARET;
			"=": if (c == "=") begin two = 1; return K_EQ2; end else return K_ASSIGN;
			"<": if (c == "=") begin two = 1; return K_LE; end else return K_LT;
			">": if (c == "=") begin two = 1; return K_GE; end else return K_GT;
			"!": if (c == "=") begin two = 1; return K_NE; end else return K_INVALID;
			".": return K_DOT;
			default: return K_INVALID;
		endcase
	endfunction

	function automatic void open_token(logic [7:0] c);
		sh_mode = M_IDLE;
		case (c)
			"#": sh_mode = M_COMMENT;
			8'h0a: sh_line = sat_inc(sh_line);
			" ": ;
			8'h22: begin
				sh_mode = M_STRING;
				sh_beg = sat_inc(sh_off);
				sh_beg_line = sh_line;
			end
			",": push_tok(K_COMMA, sh_off, 1, sh_line);
			";": push_tok(K_SEMI, sh_off, 1, sh_line);
			"(": push_tok(K_LPAREN, sh_off, 1, sh_line);
			")": push_tok(K_RPAREN, sh_off, 1, sh_line);
			"[": push_tok(K_LBRACK, sh_off, 1, sh_line);
			"]": push_tok(K_RBRACK, sh_off, 1, sh_line);
			"{": push_tok(K_LBRACE, sh_off, 1, sh_line);
			"}": push_tok(K_RBRACE, sh_off, 1, sh_line);
			"+", "-", "*", "/", "^", "=", "<", ">", "!", ".": begin
				sh_mode = M_OPER;
				sh_beg = sh_off;
				sh_beg_line = sh_line;
				sh_pend = c;
			end
			default:
				if (dig(c)) begin
					sh_mode = M_NUMBER;
					sh_beg = sh_off;
					sh_beg_line = sh_line;
					sh_point = 1'b0;
				end else if (alpha(c) || c == "_") begin
					sh_mode = M_WORD;
					sh_beg = sh_off;
					sh_beg_line = sh_line;
					sh_prefix = {56'd0, c};
				end else
					push_tok(K_INVALID, sh_off, 1, sh_line);
		endcase
	endfunction

	// Expected tokens of one accepted transaction go onto token_q
	function automatic void scan_item(in_item_t it);
		logic              two;
		logic [KindW-1:0]  k;
		logic [7:0]        c;
		logic [FieldW-1:0] len;
		step_toks.delete();
		c = it.source_byte;
		if (it.operation == OP_BYTE) begin
			case (sh_mode)
				M_COMMENT: if (c == 8'h0a) begin
					sh_line = sat_inc(sh_line);
					sh_mode = M_IDLE;
				end
				M_STRING:
					if (c == 8'h22) begin
						push_tok(K_STRING, sh_beg, span_len(), sh_beg_line);
						sh_mode = M_IDLE;
					end else if (c == 8'h0a)
						sh_line = sat_inc(sh_line);
				M_NUMBER:
					if (dig(c)) ;
					else if (c == "." && !sh_point) sh_point = 1'b1;
					else begin
						push_tok(K_NUMBER, sh_beg, span_len(), sh_beg_line);
						open_token(c);
					end
				M_WORD:
					if (alpha(c) || dig(c) || c == "_") begin
						len = span_len();
						if (len < 8) sh_prefix[8*len +: 8] = c;
					end else begin
						word_done();
						open_token(c);
					end
				M_OPER:
					if (sh_pend == "." && dig(c)) begin
						sh_mode = M_NUMBER;
						sh_point = 1'b1;
					end else begin
						k = op_kind(sh_pend, c, two);
						if (two) begin
							push_tok(k, sh_beg, 2, sh_beg_line);
							sh_mode = M_IDLE;
						end else begin
							push_tok(k, sh_beg, 1, sh_beg_line);
							open_token(c);
						end
					end
				default: open_token(c);
			endcase
			sh_off = sat_inc(sh_off);
		end else begin
			// end of text: flush what is pending, then EOF
			case (sh_mode)
				M_NUMBER: push_tok(K_NUMBER, sh_beg, span_len(), sh_beg_line);
				M_WORD: word_done();
				M_STRING: push_tok(K_INVALID, sh_beg, 1, sh_beg_line);
				M_OPER: push_tok(op_kind(sh_pend, 8'h00, two), sh_beg, 1, sh_beg_line);
				default: ;
			endcase
			push_tok(K_EOF, sh_off, 1, sh_line);
			sh_clear();
		end
		if (step_toks.size() > 0)
			step_toks[step_toks.size()-1].last_of_run = 1'b1;
		foreach (step_toks[i])
			token_q.push_back(step_toks[i]);
	endfunction

	function automatic void put_byte(logic [7:0] c);
		in_item_t t;
		t.operation = OP_BYTE;
		t.source_byte = c;
		src_q.push_back(t);
	endfunction

	function automatic void put_text(string s);
		for (int i = 0; i < s.len(); i++)
			put_byte(s[i]);
	endfunction

	function automatic void put_end();
		in_item_t t;
		t.operation = OP_END;
		t.source_byte = 8'($urandom_range(0, 255));
		src_q.push_back(t);
	endfunction

	// One random statement-ish fragment of mostly well-formed source
	function automatic string rand_fragment();
		string kws[20] = '{"and", "as", "class", "const", "elif", "else", "for",
			"function", "if", "load", "module", "none", "not", "or", "print",
			"return", "static", "use", "var", "while"};
		string ops[28] = '{"+=", "++", "+", "-=", "--", "-", "*=", "*", "/=", "/",
			"^=", "^", ",", ";", "(", ")", "[", "]", "{", "}", "==", "=", "<=", "<",
			">=", ">", "!=", "."};
		string s;
		int    n;
		case ($urandom_range(0, 9))
			0, 1: s = kws[$urandom_range(0, 19)];
			2: begin
				s = "";
				n = $urandom_range(1, 12);
				for (int i = 0; i < n; i++)
					case ($urandom_range(0, 3))
						0: s = {s, string'(8'("a" + $urandom_range(0, 25)))};
						1: s = {s, string'(8'("A" + $urandom_range(0, 25)))};
						2: s = {s, string'(8'("0" + $urandom_range(0, 9)))};
						default: s = {s, "_"};
					endcase
				if (s[0] >= "0" && s[0] <= "9") s = {"_", s};
			end
			3: begin
				s = $sformatf("%0d", $urandom_range(0, 99999));
				case ($urandom_range(0, 3))
					0: s = {s, ".", $sformatf("%0d", $urandom_range(0, 999))};
					1: s = {s, "."};
					2: s = {".", s};
					default: ;
				endcase
			end
			4: s = {"\"", (($urandom_range(0, 3) == 0) ? "ab\ncd" : "text x"), "\""};
			5: s = {"# note ", ops[$urandom_range(0, 27)], "\n"};
			6, 7: s = ops[$urandom_range(0, 27)];
			8: s = "\n";
			default: s = "!";
		endcase
		return {s, ($urandom_range(0, 2) == 0) ? "" : " "};
	endfunction

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	initial begin
		logic [7:0] b;
		int         total;
		errors = 0;
		stim_done = 0;
		send_idle_pct = 7;
		recv_idle_pct = 57;
		sh_clear();

		// directed: every keyword, every operator, special cases
		put_text("and as class const elif else for function if load module none ");
		put_end();
		put_text("not or print return static use var while");
		put_end();
		put_text("+= ++ + -= -- - *= * /= / ^= ^ , ; ( ) [ ] { } == = <= < >= > != .");
		put_end();
		put_text("12.5 7. 3.4.5 .25 !x # skip +\nfoo_9 \"s\nx\"");
		put_byte(8'h09); put_byte(8'h0d); put_byte(8'h00); put_byte(8'h80); put_byte(8'hff);
		put_byte(8'h7f);
		put_text("whi");
		put_end();
		put_text("\"open");
		put_end();
		put_text("!");
		put_end();
		put_end();

		// random: mostly well-formed text, some raw noise
		for (int i = 0; i < 1000; ) begin
			if ($urandom_range(0, 9) == 0) begin
				b = 8'($urandom_range(0, 255));
				put_byte(b);
				i++;
			end else begin
				string f;
				f = rand_fragment();
				put_text(f);
				i += f.len();
			end
			if ($urandom_range(0, 40) == 0)
				put_end();
		end
		put_end();

		// idling profiles: sender light / receiver heavy, swapped, then none
		total = src_q.size();
		while (src_q.size() > (total * 2) / 3) @(posedge clk);
		send_idle_pct = 57; recv_idle_pct = 7;
		while (src_q.size() > total / 3) @(posedge clk);
		send_idle_pct = 0; recv_idle_pct = 0;
		while (src_q.size() > 0) @(posedge clk);
		stim_done = 1;
	end

	// Reset, then watch for the end
	initial begin
		arst_n = 1'b0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		wait (stim_done && token_q.size() == 0);
		repeat (20) @(posedge clk);
		if (errors == 0 && token_q.size() == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

	// Driver: holds a transaction until accepted
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			in_data <= '0;
		end else begin
			if (in_valid && !in_stall) begin
				scan_item(in_data);
				void'(src_q.pop_front());
			end
			if (!in_valid || !in_stall) begin
				if (src_q.size() > 0 && $urandom_range(0, 99) >= send_idle_pct) begin
					in_valid <= 1'b1;
					in_data <= src_q[0];
				end else
					in_valid <= 1'b0;
			end
		end
	end

	// Monitor and receiver stall
	always @(posedge clk or negedge arst_n) begin
		out_item_t e;
		if (!arst_n) begin
			out_stall <= 1'b0;
			cycles <= 0;
		end else begin
			cycles <= cycles + 1;
			if (cycles > CycleLimit) begin
				$display("Testbench completed WITH ERRORS");
				$finish;
			end
			if (out_valid && !out_stall) begin
				if (token_q.size() == 0) begin
					$error("token with no expectation: kind %0d", out_data.token_kind);
					errors++;
				end else begin
					e = token_q.pop_front();
					if (out_data.token_kind !== e.token_kind) begin
						$error("token_kind exp %0d got %0d", e.token_kind, out_data.token_kind);
						errors++;
					end
					if (out_data.token_start !== e.token_start) begin
						$error("token_start exp %0d got %0d", e.token_start, out_data.token_start);
						errors++;
					end
					if (out_data.token_length !== e.token_length) begin
						$error("token_length exp %0d got %0d", e.token_length,
							out_data.token_length);
						errors++;
					end
					if (out_data.token_line !== e.token_line) begin
						$error("token_line exp %0d got %0d", e.token_line, out_data.token_line);
						errors++;
					end
					if (out_data.last_of_run !== e.last_of_run) begin
						$error("last_of_run exp %0d got %0d", e.last_of_run,
							out_data.last_of_run);
						errors++;
					end
				end
			end
			out_stall <= ($urandom_range(0, 99) < recv_idle_pct);
		end
	end

endmodule

// ===== filelist.f =====
rtl/sts_pkg.sv
rtl/sts_queue.sv
rtl/sts_back.sv
rtl/script_token_scanner.sv
rtl/sts_checker.sv
sim/tb_script_token_scanner.sv
